### sv/abscl_pkg.sv
// Shared types, constants and helpers for the scan clustering block.
`default_nettype none
package abscl_pkg;
  localparam int unsigned MaxClustersDef = 32;
  localparam int unsigned PosW   = 18;
  localparam int unsigned RangeW = 17;
  localparam int unsigned IdW    = 5;
  localparam int unsigned CntW   = 12;
  localparam int unsigned EvW    = 3;
  localparam int unsigned DistW  = 37;
  localparam int unsigned CfgW   = 17;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [CfgIdxW-1:0] REG_RATIO  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SIGMA  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_RECON  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_MINPTS = 2'd3;

  localparam logic [EvW-1:0] EV_DROP   = 3'd0;
  localparam logic [EvW-1:0] EV_NEW    = 3'd1;
  localparam logic [EvW-1:0] EV_APPEND = 3'd2;
  localparam logic [EvW-1:0] EV_RECON  = 3'd3;
  localparam logic [EvW-1:0] EV_FULL   = 3'd4;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_DIST,
    CELL_DSHIFT,
    CELL_LOAD,
    CELL_TAKE,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic [IdW-1:0]         id;
    logic [CntW-1:0]        cnt;
  } cell_data_t;

  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] c);
    bump = (c == CntMax) ? c : c + CntW'(1);
  endfunction
endpackage
`default_nettype wire

### sv/abscl_cell.sv
// One cluster cell: tail point, id, count and a shiftable squared distance.
`default_nettype none
module abscl_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire abscl_pkg::cell_op_e           op_i,
  input  wire logic signed [abscl_pkg::PosW-1:0] pt_x_i,
  input  wire logic signed [abscl_pkg::PosW-1:0] pt_y_i,
  input  wire abscl_pkg::cell_data_t         load_i,
  input  wire abscl_pkg::cell_data_t         nbr_i,
  input  wire logic [abscl_pkg::DistW-1:0]   nbr_d_i,
  output abscl_pkg::cell_data_t              data_o,
  output logic [abscl_pkg::DistW-1:0]        d_o
);
  import abscl_pkg::*;

  cell_data_t data_q, data_d;
  logic [DistW-1:0] d_q, d_d;
  logic signed [PosW:0] dx, dy;
  logic [PosW-1:0] ax, ay;
  logic [2*PosW-1:0] sx, sy;

  always_comb begin
    dx = {pt_x_i[PosW-1], pt_x_i} - {data_q.x[PosW-1], data_q.x};
    dy = {pt_y_i[PosW-1], pt_y_i} - {data_q.y[PosW-1], data_q.y};
    ax = dx[PosW] ? PosW'(-dx) : dx[PosW-1:0];
    ay = dy[PosW] ? PosW'(-dy) : dy[PosW-1:0];
    sx = ax * ax;
    sy = ay * ay;
    data_d = data_q;
    d_d    = d_q;
    case (op_i)
      CELL_DIST:   d_d = DistW'(sx) + DistW'(sy);
      CELL_DSHIFT: d_d = nbr_d_i;
      CELL_LOAD:   data_d = load_i;
      CELL_TAKE:   data_d = nbr_i;
      CELL_CLEAR:  data_d = '0;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
      d_q    <= '0;
    end else begin
      data_q <= data_d;
      d_q    <= d_d;
    end
  end

  assign data_o = data_q;
  assign d_o    = d_q;
endmodule
`default_nettype wire

### sv/adaptive_breakpoint_scan_clustering.sv
// Top level: scan point clustering over a chain of cluster cells.
//
// channel | direction | handshake          | payload
// in      | sink      | in_valid/in_ready  | pos_x_mm, pos_y_mm, range_mm, flags
// out     | source    | out_valid/out_ready| record_kind, cluster_id, point_event, ...
// cfg     | sink      | cfg_we             | cfg_idx, cfg_wdata
//
// The report beat is registered in ST_REP after ST_THR, ST_SQ and ST_DEC if the
// point appends, starts the first cluster or is dropped; otherwise ST_MIN and
// ST_PICK come between, as the distances of the live clusters shift one cell a
// cycle past the minimum search at cell 0. Input is ready again after the report,
// or at scan end after the summary walk over all MAX_CLUSTERS cells clears them.
// Reset clears cells, config and control registers; no clearing pass is needed.
// A stalled output beat holds the sequencer; one point is in flight at a time.
`default_nettype none
module adaptive_breakpoint_scan_clustering #(
  parameter int unsigned MAX_CLUSTERS = abscl_pkg::MaxClustersDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [abscl_pkg::PosW-1:0]   pos_x_mm_i,
  input  wire logic signed [abscl_pkg::PosW-1:0]   pos_y_mm_i,
  input  wire logic [abscl_pkg::RangeW-1:0]        range_mm_i,
  input  wire logic                                point_valid_i,
  input  wire logic                                on_track_i,
  input  wire logic                                scan_end_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     record_kind_o,
  output logic [abscl_pkg::IdW-1:0]                cluster_id_o,
  output logic [abscl_pkg::EvW-1:0]                point_event_o,
  output logic [abscl_pkg::CntW-1:0]               cluster_points_o,
  output logic                                     last_of_scan_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [abscl_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [abscl_pkg::CfgW-1:0]          cfg_wdata_i
);
  import abscl_pkg::*;

  localparam int unsigned IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned CW = $clog2(MAX_CLUSTERS + 1);
  localparam logic [IW-1:0] LastCell = IW'(MAX_CLUSTERS - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(MAX_CLUSTERS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_THR  = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;
  localparam logic [2:0] ST_MIN  = 3'd4;
  localparam logic [2:0] ST_PICK = 3'd5;
  localparam logic [2:0] ST_REP  = 3'd6;
  localparam logic [2:0] ST_SUM  = 3'd7;

  // configuration
  logic [15:0]       ratio_q;
  logic [15:0]       sigma_q;
  logic [RangeW-1:0] recon_q;
  logic [CntW-1:0]   minpts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q  <= '0;
      sigma_q  <= '0;
      recon_q  <= '0;
      minpts_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RATIO:  ratio_q  <= cfg_wdata_i[15:0];
        REG_SIGMA:  sigma_q  <= cfg_wdata_i[15:0];
        REG_RECON:  recon_q  <= cfg_wdata_i[RangeW-1:0];
        REG_MINPTS: minpts_q <= cfg_wdata_i[CntW-1:0];
        default:    ;
      endcase
    end
  end

  // sequencer state
  logic [2:0]              state_q, state_d;
  logic [CW-1:0]           total_q, total_d;
  logic [IW-1:0]           scan_q, scan_d;
  logic [IW-1:0]           best_i_q, best_i_d;
  logic [DistW-1:0]        best_q, best_d;
  logic [MAX_CLUSTERS-1:0] qmask_q, qmask_d;

  // latched point and report
  logic signed [PosW-1:0] px_q, py_q;
  logic [RangeW-1:0]      rng_q;
  logic                   keep_q, end_q;
  logic [PosW-1:0]        thr_q;
  logic [2*PosW-1:0]      thr_sq_q;
  logic [EvW-1:0]         rep_ev_q, rep_ev_d;
  logic [IdW-1:0]         rep_id_q, rep_id_d;
  logic [CntW-1:0]        rep_cnt_q, rep_cnt_d;

  // output register
  logic            ov_q, ov_d;
  logic            o_kind_q, o_kind_d, o_last_q, o_last_d;
  logic [IdW-1:0]  o_id_q, o_id_d;
  logic [EvW-1:0]  o_ev_q, o_ev_d;
  logic [CntW-1:0] o_cnt_q, o_cnt_d;

  // cell chain
  cell_op_e            cell_op [MAX_CLUSTERS];
  cell_data_t          cell_data [MAX_CLUSTERS];
  logic [DistW-1:0]    cell_d [MAX_CLUSTERS];
  cell_data_t          nbr [MAX_CLUSTERS];
  logic [DistW-1:0]    nbr_d [MAX_CLUSTERS];
  cell_data_t          load;
  logic [IW-1:0]       rd_idx;
  cell_data_t          rd;

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    if (g == MAX_CLUSTERS - 1) begin : g_end
      assign nbr[g]   = '0;
      assign nbr_d[g] = '0;
    end else begin : g_mid
      assign nbr[g]   = cell_data[g+1];
      assign nbr_d[g] = cell_d[g+1];
    end
    abscl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op[g]),
      .pt_x_i  (px_q),
      .pt_y_i  (py_q),
      .load_i  (load),
      .nbr_i   (nbr[g]),
      .nbr_d_i (nbr_d[g]),
      .data_o  (cell_data[g]),
      .d_o     (cell_d[g])
    );
  end

  logic [IW-1:0]          last_idx;
  logic                   out_free;
  logic [RangeW+16-1:0]   prod;
  logic [MAX_CLUSTERS-1:0] qmask_now;
  logic                   more_sum;
  logic [2*RangeW-1:0]    recon_sq;

  assign last_idx = IW'(total_q - CW'(1));
  assign out_free = !ov_q || out_ready_i;
  assign prod     = rng_q * ratio_q;
  assign recon_sq = recon_q * recon_q;
  assign rd       = cell_data[rd_idx];

  always_comb begin
    more_sum = 1'b0;
    for (int k = 0; k < MAX_CLUSTERS; k++) begin
      qmask_now[k] = (CW'(k) < total_q) && (cell_data[k].cnt >= minpts_q);
      if (IW'(k) > scan_q && qmask_q[k]) more_sum = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      px_q   <= pos_x_mm_i;
      py_q   <= pos_y_mm_i;
      rng_q  <= range_mm_i;
      keep_q <= point_valid_i && on_track_i;
      end_q  <= scan_end_i;
    end
    thr_q    <= PosW'(prod[RangeW+16-1:16]) + PosW'(sigma_q);
    thr_sq_q <= thr_q * thr_q;
  end

  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    scan_d    = scan_q;
    best_i_d  = best_i_q;
    best_d    = best_q;
    qmask_d   = qmask_q;
    rep_ev_d  = rep_ev_q;
    rep_id_d  = rep_id_q;
    rep_cnt_d = rep_cnt_q;
    ov_d      = ov_q && !out_ready_i;
    o_kind_d  = o_kind_q;
    o_id_d    = o_id_q;
    o_ev_d    = o_ev_q;
    o_cnt_d   = o_cnt_q;
    o_last_d  = o_last_q;
    rd_idx    = last_idx;
    load      = '{x: px_q, y: py_q, id: '0, cnt: CntW'(1)};
    for (int k = 0; k < MAX_CLUSTERS; k++) cell_op[k] = CELL_HOLD;

    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_THR;
      ST_THR: begin
        for (int k = 0; k < MAX_CLUSTERS; k++) cell_op[k] = CELL_DIST;
        state_d = ST_SQ;
      end
      ST_SQ: state_d = ST_DEC;
      ST_DEC: begin
        state_d   = ST_REP;
        rep_ev_d  = EV_DROP;
        rep_id_d  = '0;
        rep_cnt_d = '0;
        if (!keep_q) begin
          rep_ev_d = EV_DROP;
        end else if (total_q == '0) begin
          cell_op[0] = CELL_LOAD;
          total_d    = CW'(1);
          rep_ev_d   = EV_NEW;
          rep_cnt_d  = CntW'(1);
        end else if (DistW'(cell_d[last_idx]) < DistW'(thr_sq_q)) begin
          load.id           = rd.id;
          load.cnt          = bump(rd.cnt);
          cell_op[last_idx] = CELL_LOAD;
          rep_ev_d          = EV_APPEND;
          rep_id_d          = rd.id;
          rep_cnt_d         = bump(rd.cnt);
        end else begin
          scan_d  = '0;
          state_d = ST_MIN;
        end
      end
      ST_MIN: begin
        // distances march towards cell 0, one cell a cycle
        if (scan_q == '0 || cell_d[0] < best_q) begin
          best_d   = cell_d[0];
          best_i_d = scan_q;
        end
        for (int k = 0; k < MAX_CLUSTERS; k++) cell_op[k] = CELL_DSHIFT;
        scan_d = scan_q + IW'(1);
        if (scan_q == last_idx) state_d = ST_PICK;
      end
      ST_PICK: begin
        rd_idx  = best_i_q;
        state_d = ST_REP;
        if (best_q < DistW'(recon_sq)) begin
          load.id  = rd.id;
          load.cnt = bump(rd.cnt);
          for (int k = 0; k < MAX_CLUSTERS; k++) begin
            if (IW'(k) >= best_i_q && IW'(k) < last_idx) cell_op[k] = CELL_TAKE;
          end
          cell_op[last_idx] = CELL_LOAD;
          rep_ev_d  = EV_RECON;
          rep_id_d  = rd.id;
          rep_cnt_d = bump(rd.cnt);
        end else if (total_q < FullCnt) begin
          load.id              = IdW'(total_q);
          cell_op[IW'(total_q)] = CELL_LOAD;
          total_d   = total_q + CW'(1);
          rep_ev_d  = EV_NEW;
          rep_id_d  = IdW'(total_q);
          rep_cnt_d = CntW'(1);
        end else begin
          rep_ev_d = EV_FULL;
        end
      end
      ST_REP: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_kind_d = 1'b0;
          o_id_d   = rep_id_q;
          o_ev_d   = rep_ev_q;
          o_cnt_d  = rep_cnt_q;
          o_last_d = end_q && !(|qmask_now);
          qmask_d  = qmask_now;
          scan_d   = '0;
          state_d  = end_q ? ST_SUM : ST_IDLE;
        end
      end
      ST_SUM: begin
        rd_idx = scan_q;
        if (!qmask_q[scan_q] || out_free) begin
          if (qmask_q[scan_q]) begin
            ov_d     = 1'b1;
            o_kind_d = 1'b1;
            o_id_d   = rd.id;
            o_ev_d   = EV_DROP;
            o_cnt_d  = rd.cnt;
            o_last_d = !more_sum;
          end
          if (scan_q == LastCell) begin
            for (int k = 0; k < MAX_CLUSTERS; k++) cell_op[k] = CELL_CLEAR;
            total_d = '0;
            state_d = ST_IDLE;
          end else begin
            scan_d = scan_q + IW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      scan_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      scan_q  <= scan_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_i_q  <= best_i_d;
    best_q    <= best_d;
    qmask_q   <= qmask_d;
    rep_ev_q  <= rep_ev_d;
    rep_id_q  <= rep_id_d;
    rep_cnt_q <= rep_cnt_d;
    o_kind_q  <= o_kind_d;
    o_id_q    <= o_id_d;
    o_ev_q    <= o_ev_d;
    o_cnt_q   <= o_cnt_d;
    o_last_q  <= o_last_d;
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = ov_q;
  assign record_kind_o    = o_kind_q;
  assign cluster_id_o     = o_id_q;
  assign point_event_o    = o_ev_q;
  assign cluster_points_o = o_cnt_q;
  assign last_of_scan_o   = o_last_q;
endmodule
`default_nettype wire

### tb/sv/adaptive_breakpoint_scan_clustering_tb.sv
// Testbench for the scan clustering block: random and directed scans checked against a predictor.
`default_nettype none
module adaptive_breakpoint_scan_clustering_tb;
  import abscl_pkg::*;

  localparam int unsigned NCells    = MaxClustersDef;
  // Longest point: a minimum search over all live clusters, then the summary walk and clear.
  localparam int unsigned SettleCyc = 4 + 2 * NCells + 16;
  localparam int unsigned StallCyc  = 400;
  localparam int unsigned DogLimit  = 4000;

  typedef struct {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic [RangeW-1:0]      rng;
    logic                   ok;
    logic                   trk;
    logic                   fin;
  } point_t;

  typedef struct {
    logic            kind;
    logic [IdW-1:0]  id;
    logic [EvW-1:0]  ev;
    logic [CntW-1:0] cnt;
    logic            last;
  } record_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [PosW-1:0] pos_x = '0;
  logic signed [PosW-1:0] pos_y = '0;
  logic [RangeW-1:0]      range_mm = '0;
  logic                   pt_ok = 1'b0;
  logic                   pt_trk = 1'b0;
  logic                   pt_fin = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   rec_kind;
  logic [IdW-1:0]         rec_id;
  logic [EvW-1:0]         rec_ev;
  logic [CntW-1:0]        rec_cnt;
  logic                   rec_last;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx = '0;
  logic [CfgW-1:0]        cfg_wdata = '0;

  always #4 clk = ~clk;

  adaptive_breakpoint_scan_clustering u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .pos_x_mm_i      (pos_x),
    .pos_y_mm_i      (pos_y),
    .range_mm_i      (range_mm),
    .point_valid_i   (pt_ok),
    .on_track_i      (pt_trk),
    .scan_end_i      (pt_fin),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .record_kind_o   (rec_kind),
    .cluster_id_o    (rec_id),
    .point_event_o   (rec_ev),
    .cluster_points_o(rec_cnt),
    .last_of_scan_o  (rec_last),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // Predictor: its own copy of the registers and the cluster list
  // ---------------------------------------------------------------------
  logic [15:0]            m_ratio;
  logic [15:0]            m_sigma;
  logic [16:0]            m_recon;
  logic [11:0]            m_minpts;
  logic signed [PosW-1:0] m_tx [NCells];
  logic signed [PosW-1:0] m_ty [NCells];
  logic [IdW-1:0]         m_id [NCells];
  logic [CntW-1:0]        m_cnt [NCells];
  int unsigned            m_live;

  point_t  pending_pts[$];
  record_t expected_recs[$];
  int      fail_cnt = 0;

  function automatic longint unsigned sq_dist(logic signed [PosW-1:0] ax,
                                              logic signed [PosW-1:0] ay,
                                              logic signed [PosW-1:0] bx,
                                              logic signed [PosW-1:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return longint'(dx * dx + dy * dy);
  endfunction

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] c);
    return (c == {CntW{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic void clear_list();
    for (int i = 0; i < NCells; i++) begin
      m_tx[i] = '0; m_ty[i] = '0; m_id[i] = '0; m_cnt[i] = '0;
    end
    m_live = 0;
  endfunction

  // Works out the report (and summaries on scan end) for one accepted point.
  function automatic void cluster_point(point_t p);
    record_t         rep;
    record_t         summ;
    longint unsigned thr;
    longint unsigned d;
    longint unsigned best_d;
    int unsigned     best;
    int unsigned     tail;
    logic [IdW-1:0]  cid;
    logic [CntW-1:0] ccnt;
    int              n_summ;

    rep = '{kind: 1'b0, id: '0, ev: EV_DROP, cnt: '0, last: p.fin};
    if (!p.ok || !p.trk) begin
      rep.ev = EV_DROP;
    end else if (m_live == 0) begin
      m_tx[0] = p.x; m_ty[0] = p.y; m_id[0] = '0; m_cnt[0] = CntW'(1);
      m_live = 1;
      rep.ev = EV_NEW; rep.cnt = CntW'(1);
    end else begin
      tail = m_live - 1;
      thr = ((longint'(p.rng) * longint'(m_ratio)) >> 16) + longint'(m_sigma);
      d = sq_dist(p.x, p.y, m_tx[tail], m_ty[tail]);
      if (d < thr * thr) begin
        m_tx[tail] = p.x; m_ty[tail] = p.y;
        m_cnt[tail] = sat_inc(m_cnt[tail]);
        rep.ev = EV_APPEND; rep.id = m_id[tail]; rep.cnt = m_cnt[tail];
      end else begin
        best = 0;
        best_d = sq_dist(p.x, p.y, m_tx[0], m_ty[0]);
        for (int unsigned i = 1; i < m_live; i++) begin
          d = sq_dist(p.x, p.y, m_tx[i], m_ty[i]);
          if (d < best_d) begin
            best_d = d; best = i;
          end
        end
        if (best_d < longint'(m_recon) * longint'(m_recon)) begin
          // rejoin and move that cluster to the back of the list
          cid = m_id[best];
          ccnt = sat_inc(m_cnt[best]);
          for (int unsigned i = best; i + 1 < m_live; i++) begin
            m_tx[i] = m_tx[i+1]; m_ty[i] = m_ty[i+1];
            m_id[i] = m_id[i+1]; m_cnt[i] = m_cnt[i+1];
          end
          m_tx[tail] = p.x; m_ty[tail] = p.y; m_id[tail] = cid; m_cnt[tail] = ccnt;
          rep.ev = EV_RECON; rep.id = cid; rep.cnt = ccnt;
        end else if (m_live < NCells) begin
          m_tx[m_live] = p.x; m_ty[m_live] = p.y;
          m_id[m_live] = IdW'(m_live); m_cnt[m_live] = CntW'(1);
          rep.ev = EV_NEW; rep.id = IdW'(m_live); rep.cnt = CntW'(1);
          m_live++;
        end else begin
          rep.ev = EV_FULL;
        end
      end
    end

    n_summ = 0;
    if (p.fin) begin
      for (int unsigned i = 0; i < m_live; i++)
        if (m_cnt[i] >= m_minpts) n_summ++;
      if (n_summ != 0) rep.last = 1'b0;
    end
    expected_recs.insert(expected_recs.size(), rep);
    if (p.fin) begin
      for (int unsigned i = 0; i < m_live; i++) begin
        if (m_cnt[i] >= m_minpts) begin
          n_summ--;
          summ = '{kind: 1'b1, id: m_id[i], ev: EV_DROP, cnt: m_cnt[i],
                   last: (n_summ == 0)};
          expected_recs.insert(expected_recs.size(), summ);
        end
      end
      clear_list();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver: point beats from the pending queue, random gaps
  // ---------------------------------------------------------------------
  logic in_taken = 1'b0;
  int   src_gap = 0;

  always @(negedge clk) begin
    point_t p;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_pts.size() != 0) begin
        p = pending_pts.pop_front();
        pos_x <= p.x; pos_y <= p.y; range_mm <= p.rng;
        pt_ok <= p.ok; pt_trk <= p.trk; pt_fin <= p.fin;
        in_valid <= 1'b1;
        // mostly back to back, some short gaps, a few long ones
        case ($urandom_range(0, 9))
          0, 1, 2:  src_gap <= $urandom_range(1, 3);
          3:        src_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : 0;
          default:  src_gap <= 0;
        endcase
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold-off on request
  // ---------------------------------------------------------------------
  int stall_req = 0;
  int stall_served = 0;
  int stall_left = 0;
  int sink_gap = 0;

  always @(negedge clk) begin
    if (stall_req != stall_served) begin
      stall_served <= stall_req;
      stall_left <= StallCyc;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      case ($urandom_range(0, 9))
        0, 1:    sink_gap <= $urandom_range(1, 3);
        2:       sink_gap <= ($urandom_range(0, 4) == 0) ? $urandom_range(10, 50) : 0;
        default: sink_gap <= 0;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check result beats, then predict from point beats
  // ---------------------------------------------------------------------
  int idle_cyc = 0;

  always @(posedge clk) begin
    record_t e;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_recs.size() == 0) begin
          $error("unexpected result beat: kind %0d id %0d ev %0d cnt %0d last %0d",
                 rec_kind, rec_id, rec_ev, rec_cnt, rec_last);
          fail_cnt++;
        end else begin
          e = expected_recs.pop_front();
          if (rec_kind !== e.kind) begin
            $error("record_kind: exp %0d got %0d", e.kind, rec_kind); fail_cnt++;
          end
          if (rec_id !== e.id) begin
            $error("cluster_id: exp %0d got %0d", e.id, rec_id); fail_cnt++;
          end
          if (rec_ev !== e.ev) begin
            $error("point_event: exp %0d got %0d", e.ev, rec_ev); fail_cnt++;
          end
          if (rec_cnt !== e.cnt) begin
            $error("cluster_points: exp %0d got %0d", e.cnt, rec_cnt); fail_cnt++;
          end
          if (rec_last !== e.last) begin
            $error("last_of_scan: exp %0d got %0d", e.last, rec_last); fail_cnt++;
          end
        end
      end
      if (in_valid && in_ready)
        cluster_point('{x: pos_x, y: pos_y, rng: range_mm,
                        ok: pt_ok, trk: pt_trk, fin: pt_fin});
      // watchdog on cycles with no beat on either side
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= DogLimit) begin
        $display("adaptive_breakpoint_scan_clustering_tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  task automatic add_pt(int x, int y, int r, bit ok, bit trk, bit fin);
    pending_pts.insert(pending_pts.size(),
                       '{x: PosW'(x), y: PosW'(y), rng: RangeW'(r),
                         ok: ok, trk: trk, fin: fin});
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= CfgW'(val);
    case (idx)
      REG_RATIO:  m_ratio  = val[15:0];
      REG_SIGMA:  m_sigma  = val[15:0];
      REG_RECON:  m_recon  = val[16:0];
      REG_MINPTS: m_minpts = val[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int unsigned ratio, int unsigned sigma,
                          int unsigned recon, int unsigned minpts);
    write_reg(REG_RATIO, ratio);
    write_reg(REG_SIGMA, sigma);
    write_reg(REG_RECON, recon);
    write_reg(REG_MINPTS, minpts);
  endtask

  // waits until every point is sent and the last result is back, then the block settles
  task automatic drain();
    while (pending_pts.size() != 0 || in_valid || expected_recs.size() != 0)
      @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  // Scans that mostly walk in small steps, revisit old spots, or jump.
  task automatic random_scans(int n_items);
    int cx, cy, len, r;
    int ax[4], ay[4];
    bit ok, trk;
    while (n_items > 0) begin
      len = $urandom_range(3, 30);
      cx = $urandom_range(0, 8000) - 4000;
      cy = $urandom_range(0, 8000) - 4000;
      for (int i = 0; i < 4; i++) begin
        ax[i] = cx; ay[i] = cy;
      end
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          cx += $urandom_range(0, 300) - 150;
          cy += $urandom_range(0, 300) - 150;
        end else if (r < 85) begin
          r = $urandom_range(0, 3);
          cx = ax[r] + $urandom_range(0, 60) - 30;
          cy = ay[r] + $urandom_range(0, 60) - 30;
        end else if (r < 95) begin
          cx = $urandom_range(0, 20000) - 10000;
          cy = $urandom_range(0, 20000) - 10000;
          ax[$urandom_range(0, 3)] = cx;
        end else begin
          cx = $urandom_range(0, 262143) - 131072;
          cy = $urandom_range(0, 262143) - 131072;
        end
        ok = ($urandom_range(0, 9) != 0);
        trk = ($urandom_range(0, 11) != 0);
        r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                        : $urandom_range(200, 20000);
        add_pt(cx, cy, r, ok, trk, k == len - 1);
        cx = 32'(PosW'(cx));
        cy = 32'(PosW'(cy));
        if (k == len - 1) n_items -= len;
      end
    end
  endtask

  initial begin
    m_ratio = '0; m_sigma = '0; m_recon = '0; m_minpts = '0;
    clear_list();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero thresholds: nothing appends or reconnects, so the table fills.
    add_pt(100, 100, 500, 1'b0, 1'b1, 1'b0);
    add_pt(100, 100, 500, 1'b1, 1'b0, 1'b0);
    add_pt(0, 0, 0, 1'b0, 1'b0, 1'b1);          // scan end, empty table
    for (int k = 0; k < 36; k++)
      add_pt(k * 1000, -k * 500, 131071, 1'b1, 1'b1, 1'b0);
    add_pt(7, 7, 0, 1'b0, 1'b1, 1'b1);          // scan end on a dropped point
    drain();

    // Extreme settings and coordinates.
    set_regs(65535, 65535, 131071, 0);
    add_pt(-131072, -131072, 131071, 1'b1, 1'b1, 1'b0);
    add_pt(131071, 131071, 0, 1'b1, 1'b1, 1'b0);
    add_pt(131071, -131072, 131071, 1'b1, 1'b1, 1'b0);
    add_pt(0, 0, 65536, 1'b1, 1'b1, 1'b0);
    add_pt(-1, 1, 1, 1'b1, 1'b1, 1'b0);
    add_pt(-131072, 131071, 131071, 1'b1, 1'b1, 1'b1);
    drain();

    // Threshold tiny, wide reconnect radius: nearby jumps reconnect to the one cluster.
    set_regs(0, 1, 1000, 2);
    add_pt(0, 0, 100, 1'b1, 1'b1, 1'b0);
    add_pt(400, 0, 100, 1'b1, 1'b1, 1'b0);
    add_pt(200, 0, 100, 1'b1, 1'b1, 1'b0);      // reconnects to cluster 0
    add_pt(200, 0, 100, 1'b1, 1'b1, 1'b0);      // appends
    add_pt(5000, 5000, 100, 1'b1, 1'b1, 1'b1);
    drain();

    // Repeated appends on one spot.
    set_regs(0, 1, 0, 30);
    for (int k = 0; k < 40; k++)
      add_pt(5, 5, 0, 1'b1, 1'b1, k == 39);
    drain();

    // Random settings and scans; one phase runs with a long receiver hold-off.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) set_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 131071), $urandom_range(0, 4095));
      else set_regs($urandom_range(0, 4000), $urandom_range(0, 400),
                    $urandom_range(0, 3000), $urandom_range(0, 5));
      random_scans(20);
      if (ph == 2) stall_req++;
      drain();
    end

    if (fail_cnt == 0) begin
      $display("adaptive_breakpoint_scan_clustering_tb: PASS");
    end else begin
      $display("adaptive_breakpoint_scan_clustering_tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

### adaptive_breakpoint_scan_clustering.f
sv/abscl_pkg.sv
sv/abscl_cell.sv
sv/adaptive_breakpoint_scan_clustering.sv
tb/sv/adaptive_breakpoint_scan_clustering_tb.sv
